/* hdl/ppp_pkg.sv */
// shared constants for the perspective point projection block
// register indexes, fixed field widths and fixed-point constants
// no dependencies
package ppp_pkg;

   // default coordinate width, Q.8 two's complement
   localparam int COORD_WIDTH_DEF = 32;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 48;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAMERA_X         = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAMERA_Y         = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAMERA_Z         = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEPTH_ROW        = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HORIZONTAL_ROW   = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTICAL_ROW     = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROJECTION_SCALE = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_CENTER    = 4'd7;

   // matrix rows hold three Q2.14 coefficients
   localparam int ROW_WIDTH  = 48;
   localparam int COEF_WIDTH = 16;
   localparam int COEF_FRAC  = 14;

   // projection scale is unsigned Q16.16, reset to 1.0
   localparam int                    SCALE_WIDTH = 32;
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 32'h0001_0000;

   // screen centers are whole pixels, used as Q.8
   localparam int CENTER_WIDTH = 16;
   localparam int PIX_FRAC     = 8;

   // smallest depth, 1.0 in Q.8
   localparam int DEPTH_FLOOR = 256;

endpackage

/* hdl/perspective_point_projection.sv */
// perspective point projection, fully pipelined top level
// depends on ppp_pkg
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------
//  req      | in        | req_valid/req_stall | req_world_x, req_world_y, req_world_z
//  rsp      | out       | rsp_valid/rsp_stall | rsp_pixel_x, rsp_pixel_y
//  csr      | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one transaction per cycle sustained while rsp is not stalled; the pipeline has
// six arithmetic stages, COORD_WIDTH + 1 stages of the pipelined divider and one output register
// the restoring divider, one quotient bit per stage, sets the depth
// reset is synchronous and clears valid bits and configuration registers
// a stall on rsp while rsp_valid is high freezes the whole pipeline; a one-entry
// skid buffer takes a transaction arriving in that cycle, and req_stall comes from a register
module perspective_point_projection
   import ppp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input points
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_world_x,
   input  logic signed [COORD_WIDTH-1:0]     req_world_y,
   input  logic signed [COORD_WIDTH-1:0]     req_world_z,
   // projected points
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [COORD_WIDTH-1:0]     rsp_pixel_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_pixel_y,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]         csr_data
);

   localparam int W     = COORD_WIDTH;
   localparam int DW    = W + 1;                 // camera offset
   localparam int PW    = W + COEF_WIDTH + 1;    // one rotation product
   localparam int SW    = PW + 2;                // sum of three products
   localparam int CW    = W + 5;                 // rotated component
   localparam int MAG_W = W + 4;                 // component magnitude
   localparam int LO_W  = MAG_W / 2;
   localparam int HI_W  = MAG_W - LO_W;
   localparam int NW    = MAG_W + SCALE_WIDTH;   // dividend
   localparam int DVW   = W + 12;                // divisor, depth in Q.16
   localparam int RW    = DVW + 1;               // partial remainder
   localparam int RSW   = W + 3;                 // center plus offset

   localparam logic signed [CW-1:0] FLOOR_C = CW'(DEPTH_FLOOR);

   // configuration registers
   logic [W-1:0]           cam_ff [3];
   logic [ROW_WIDTH-1:0]   row_ff [3];
   logic [SCALE_WIDTH-1:0] scale_ff;
   logic [31:0]            center_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cam_ff[i] <= '0;
            row_ff[i] <= '0;
         end
         scale_ff  <= SCALE_RESET;
         center_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAMERA_X:         cam_ff[0] <= csr_data[W-1:0];
            CSR_CAMERA_Y:         cam_ff[1] <= csr_data[W-1:0];
            CSR_CAMERA_Z:         cam_ff[2] <= csr_data[W-1:0];
            CSR_DEPTH_ROW:        row_ff[0] <= csr_data[ROW_WIDTH-1:0];
            CSR_HORIZONTAL_ROW:   row_ff[1] <= csr_data[ROW_WIDTH-1:0];
            CSR_VERTICAL_ROW:     row_ff[2] <= csr_data[ROW_WIDTH-1:0];
            CSR_PROJECTION_SCALE: scale_ff  <= csr_data[SCALE_WIDTH-1:0];
            CSR_SCREEN_CENTER:    center_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // pipeline advance and input skid buffer
   logic         rsp_valid_ff;
   logic         skid_valid_ff;
   logic [W-1:0] skid_ff [3];
   logic         en;
   logic         accept;
   logic         src_vld;
   logic [W-1:0] src [3];

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign src_vld   = skid_valid_ff || accept;

   always_comb begin
      if (skid_valid_ff) begin
         src[0] = skid_ff[0];
         src[1] = skid_ff[1];
         src[2] = skid_ff[2];
      end else begin
         src[0] = req_world_x;
         src[1] = req_world_y;
         src[2] = req_world_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (en) skid_valid_ff <= 1'b0;
      end else if (accept && !en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff && accept && !en) begin
         skid_ff[0] <= req_world_x;
         skid_ff[1] <= req_world_y;
         skid_ff[2] <= req_world_z;
      end
   end

   // stage 1: offset from camera
   logic                 s1_vld_ff;
   logic signed [DW-1:0] s1_d_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (en) s1_vld_ff <= src_vld;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_d_ff[i] <= $signed({src[i][W-1], src[i]})
                        - $signed({cam_ff[i][W-1], cam_ff[i]});
         end
      end
   end

   // stage 2: nine rotation products, row by slot
   logic                 s2_vld_ff;
   logic signed [PW-1:0] s2_prod_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (en) s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int s = 0; s < 3; s++) begin
               s2_prod_ff[r][s] <= PW'(s1_d_ff[s])
                  * PW'($signed(row_ff[r][COEF_WIDTH*s +: COEF_WIDTH]));
            end
         end
      end
   end

   // stage 3: exact sums, floor division by 2^14
   logic                 s3_vld_ff;
   logic signed [CW-1:0] s3_comp_ff [3];
   logic signed [SW-1:0] s3_sum_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s3_sum_in[r] = SW'(s2_prod_ff[r][0]) + SW'(s2_prod_ff[r][1])
                      + SW'(s2_prod_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (en) s3_vld_ff <= s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            s3_comp_ff[r] <= CW'(s3_sum_in[r] >>> COEF_FRAC);
         end
      end
   end

   // stage 4: depth floor, divisor, magnitudes and signs (lane 0 x, lane 1 y)
   logic                 s4_vld_ff;
   logic [DVW-1:0]       s4_dv_ff;
   logic [MAG_W-1:0]     s4_mag_ff [2];
   logic                 s4_neg_ff [2];
   logic signed [CW-1:0] s4_depth_in;
   logic signed [CW-1:0] s4_abs_in [2];

   always_comb begin
      s4_depth_in = (s3_comp_ff[0] < FLOOR_C) ? FLOOR_C : s3_comp_ff[0];
      for (int l = 0; l < 2; l++) begin
         s4_abs_in[l] = s3_comp_ff[l+1][CW-1] ? -s3_comp_ff[l+1] : s3_comp_ff[l+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (en) s4_vld_ff <= s3_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_dv_ff     <= {s4_depth_in[MAG_W-1:0], {PIX_FRAC{1'b0}}};
         s4_mag_ff[0] <= s4_abs_in[0][MAG_W-1:0];
         s4_mag_ff[1] <= s4_abs_in[1][MAG_W-1:0];
         // the vertical axis points down on screen
         s4_neg_ff[0] <= s3_comp_ff[1][CW-1];
         s4_neg_ff[1] <= !s3_comp_ff[2][CW-1];
      end
   end

   // stage 5: scale products split in two halves
   logic                         s5_vld_ff;
   logic [DVW-1:0]               s5_dv_ff;
   logic                         s5_neg_ff [2];
   logic [LO_W+SCALE_WIDTH-1:0]  s5_plo_ff [2];
   logic [HI_W+SCALE_WIDTH-1:0]  s5_phi_ff [2];

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (en) s5_vld_ff <= s4_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_dv_ff <= s4_dv_ff;
         for (int l = 0; l < 2; l++) begin
            s5_neg_ff[l] <= s4_neg_ff[l];
            s5_plo_ff[l] <= (LO_W+SCALE_WIDTH)'(s4_mag_ff[l][LO_W-1:0])
                          * (LO_W+SCALE_WIDTH)'(scale_ff);
            s5_phi_ff[l] <= (HI_W+SCALE_WIDTH)'(s4_mag_ff[l][MAG_W-1:LO_W])
                          * (HI_W+SCALE_WIDTH)'(scale_ff);
         end
      end
   end

   // stage 6: full dividend
   logic           s6_vld_ff;
   logic [DVW-1:0] s6_dv_ff;
   logic           s6_neg_ff [2];
   logic [NW-1:0]  s6_num_ff [2];

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (en) s6_vld_ff <= s5_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_dv_ff <= s5_dv_ff;
         for (int l = 0; l < 2; l++) begin
            s6_neg_ff[l] <= s5_neg_ff[l];
            s6_num_ff[l] <= NW'(s5_plo_ff[l]) + (NW'(s5_phi_ff[l]) << LO_W);
         end
      end
   end

   // divider: stage 0 checks for overflow and loads the upper dividend bits,
   // then one quotient bit per stage; arrays are indexed stage first
   logic           dv_vld_ff [W+1];
   logic [DVW-1:0] dv_ff     [W+1];
   logic [RW-1:0]  rem_ff    [W+1][2];
   logic [W-1:0]   q_ff      [W+1][2];
   logic [W-1:0]   nlo_ff    [W+1][2];
   logic           sat_ff    [W+1][2];
   logic           neg_ff    [W+1][2];
   logic [DVW-1:0] top_in    [2];
   logic           sat_in    [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         top_in[l] = DVW'(s6_num_ff[l][NW-1:W]);
         sat_in[l] = top_in[l] >= s6_dv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else if (en) dv_vld_ff[0] <= s6_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= s6_dv_ff;
         for (int l = 0; l < 2; l++) begin
            sat_ff[0][l] <= sat_in[l];
            rem_ff[0][l] <= sat_in[l] ? '0 : RW'(top_in[l]);
            q_ff[0][l]   <= '0;
            nlo_ff[0][l] <= s6_num_ff[l][W-1:0];
            neg_ff[0][l] <= s6_neg_ff[l];
         end
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_div
      logic [RW-1:0] trial_in [2];
      logic          ge_in    [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial_in[l] = {rem_ff[k-1][l][RW-2:0], nlo_ff[k-1][l][W-k]};
            ge_in[l]    = trial_in[l] >= {1'b0, dv_ff[k-1]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[k] <= 1'b0;
         else if (en) dv_vld_ff[k] <= dv_vld_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k] <= dv_ff[k-1];
            for (int l = 0; l < 2; l++) begin
               rem_ff[k][l] <= ge_in[l] ? trial_in[l] - {1'b0, dv_ff[k-1]}
                                        : trial_in[l];
               q_ff[k][l]   <= {q_ff[k-1][l][W-2:0], ge_in[l]};
               nlo_ff[k][l] <= nlo_ff[k-1][l];
               sat_ff[k][l] <= sat_ff[k-1][l];
               neg_ff[k][l] <= neg_ff[k-1][l];
            end
         end
      end
   end

   // output: signed offset around the center, saturated to the coordinate range
   logic [W-1:0]           rsp_screen_ff [2];
   logic [W:0]             off_in    [2];
   logic [RSW-1:0]         cen_in    [2];
   logic [RSW-1:0]         sum_in    [2];
   logic [W-1:0]           res_in    [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         off_in[l] = sat_ff[W][l] ? {1'b1, {W{1'b0}}} : {1'b0, q_ff[W][l]};
         cen_in[l] = RSW'({center_ff[CENTER_WIDTH*l +: CENTER_WIDTH],
                           {PIX_FRAC{1'b0}}});
         sum_in[l] = neg_ff[W][l] ? cen_in[l] - RSW'(off_in[l])
                                  : cen_in[l] + RSW'(off_in[l]);
         if (sum_in[l][RSW-1:W-1] == {(RSW-W+1){sum_in[l][RSW-1]}}) begin
            res_in[l] = sum_in[l][W-1:0];
         end else if (sum_in[l][RSW-1]) begin
            res_in[l] = {1'b1, {(W-1){1'b0}}};
         end else begin
            res_in[l] = {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= dv_vld_ff[W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_screen_ff[0] <= res_in[0];
         rsp_screen_ff[1] <= res_in[1];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_x = $signed(rsp_screen_ff[0]);
   assign rsp_pixel_y = $signed(rsp_screen_ff[1]);

   // checks
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (src_vld && en) |=> s1_vld_ff)
      else $error("transaction lost at pipeline entry");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !en) |=> skid_valid_ff)
      else $error("skid buffer dropped a transaction while stalled");

   a_out_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(dv_vld_ff[W]))
      else $error("result without a transaction in the last divider stage");

   a_rem_x: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[W] |-> (rem_ff[W][0] < {1'b0, dv_ff[W]}))
      else $error("divider remainder not below divisor");

   a_rem_y: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[W] |-> (rem_ff[W][1] < {1'b0, dv_ff[W]}))
      else $error("divider remainder not below divisor");

endmodule

/* test/perspective_point_projection_test.sv */
// self-checking testbench for the perspective point projection block
// depends on ppp_pkg and perspective_point_projection
// directed table then random points, each checked against a given expected point or a local projection model
`timescale 1ns / 1ps

module perspective_point_projection_test;
   import ppp_pkg::*;

   localparam int W = COORD_WIDTH_DEF;
   localparam int LATENCY = W + 8;
   localparam int N_RANDOM = 1100;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [W-1:0] req_world_x = '0, req_world_y = '0, req_world_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [W-1:0] rsp_pixel_x, rsp_pixel_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   perspective_point_projection #(.COORD_WIDTH(W)) DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      logic signed [W-1:0] sx;
      logic signed [W-1:0] sy;
   } screen_point_type;

   // local copy of the configuration
   logic signed [W-1:0] cam_x, cam_y, cam_z;
   logic [ROW_WIDTH-1:0] row_d, row_h, row_v;
   logic [SCALE_WIDTH-1:0] scale;
   logic [31:0] center;

   screen_point_type pending_points[$];
   int errors = 0;
   longint cycles = 0;
   bit hold_long = 0;
   bit stall_enable = 0;

   // floor of the q14 dot product of deltas and one coefficient row
   function automatic longint rotate(longint dx, longint dy, longint dz,
                                     logic [ROW_WIDTH-1:0] row);
      logic signed [127:0] acc;
      logic signed [15:0] c0, c1, c2;
      c0 = row[15:0];
      c1 = row[31:16];
      c2 = row[47:32];
      acc = 128'(dx) * c0 + 128'(dy) * c1 + 128'(dz) * c2;
      return longint'(acc >>> COEF_FRAC);
   endfunction

   // center plus signed scaled offset, saturated
   function automatic logic signed [W-1:0] place(logic [15:0] c, longint comp,
                                                 longint depth, bit negate);
      logic [127:0] mag, q;
      logic signed [127:0] r;
      bit neg;
      neg = (comp < 0) != negate;
      mag = comp < 0 ? 128'(-comp) : 128'(comp);
      q = (mag * scale) / (128'(depth) << 8);
      if (q > (128'(1) << W)) q = 128'(1) << W;
      r = neg ? -$signed(q) : $signed(q);
      r = r + (128'(c) << PIX_FRAC);
      if (r > (128'sd1 <<< (W - 1)) - 1) r = (128'sd1 <<< (W - 1)) - 1;
      if (r < -(128'sd1 <<< (W - 1))) r = -(128'sd1 <<< (W - 1));
      return r[W-1:0];
   endfunction

   function automatic screen_point_type project(logic signed [W-1:0] x,
                                                logic signed [W-1:0] y,
                                                logic signed [W-1:0] z);
      longint dx, dy, dz, depth, horiz, vert;
      screen_point_type p;
      dx = longint'(x) - longint'(cam_x);
      dy = longint'(y) - longint'(cam_y);
      dz = longint'(z) - longint'(cam_z);
      depth = rotate(dx, dy, dz, row_d);
      horiz = rotate(dx, dy, dz, row_h);
      vert = rotate(dx, dy, dz, row_v);
      if (depth < DEPTH_FLOOR) depth = DEPTH_FLOOR;
      p.sx = place(center[15:0], horiz, depth, 1'b0);
      p.sy = place(center[31:16], vert, depth, 1'b1);
      return p;
   endfunction

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_valid = 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         CSR_CAMERA_X: cam_x = val[W-1:0];
         CSR_CAMERA_Y: cam_y = val[W-1:0];
         CSR_CAMERA_Z: cam_z = val[W-1:0];
         CSR_DEPTH_ROW: row_d = val;
         CSR_HORIZONTAL_ROW: row_h = val;
         CSR_VERTICAL_ROW: row_v = val;
         CSR_PROJECTION_SCALE: scale = val[31:0];
         CSR_SCREEN_CENTER: center = val[31:0];
         default: ;
      endcase
   endtask

   // offer one point; the transaction completes on an unstalled edge
   task automatic send_point(logic signed [W-1:0] x, logic signed [W-1:0] y,
                             logic signed [W-1:0] z, bit typed, screen_point_type want,
                             bit gaps);
      int gap;
      gap = gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0) : 0;
      repeat (gap) @(negedge clock);
      req_valid = 1'b1;
      req_world_x <= x;
      req_world_y <= y;
      req_world_z <= z;
      do @(posedge clock); while (req_stall);
      pending_points.push_back(typed ? want : project(x, y, z));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [47:0] rand_row(bit unit_ish);
      logic [47:0] r;
      r = 48'({$urandom, $urandom});
      if (unit_ish) begin
         r[15:0] = 16'($signed($urandom_range(0, 32767)) - 16384);
         r[31:16] = 16'($signed($urandom_range(0, 32767)) - 16384);
         r[47:32] = 16'($urandom_range(8192, 16384));
      end
      return r;
   endfunction

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      int wait_cycles;
      if (hold_long) begin
         rsp_stall <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
         wait_cycles = $urandom_range(0, 18);
         rsp_stall <= (wait_cycles != 0);
         repeat (wait_cycles) @(negedge clock);
         if (wait_cycles != 0) rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      screen_point_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d", $time, rsp_pixel_x, rsp_pixel_y);
            errors++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_pixel_x !== want.sx) begin
               $display("%0t: pixel_x expected %0d actual %0d", $time, want.sx, rsp_pixel_x);
               errors++;
            end
            if (rsp_pixel_y !== want.sy) begin
               $display("%0t: pixel_y expected %0d actual %0d", $time, want.sy, rsp_pixel_y);
               errors++;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("perspective_point_projection regression: fail");
         $finish;
      end
   end

   typedef struct {
      logic signed [W-1:0] x, y, z;
      bit typed;
      screen_point_type want;
   } point_row_type;

   localparam logic signed [W-1:0] MAXC = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINC = {1'b1, {(W-1){1'b0}}};

   initial begin
      point_row_type table_rows[$];
      screen_point_type zero_pt, p;
      logic signed [W-1:0] x, y, z;
      cam_x = 0; cam_y = 0; cam_z = 0;
      row_d = 0; row_h = 0; row_v = 0;
      scale = SCALE_RESET; center = 0;
      zero_pt = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset all rows are zero, so every point lands on the center
      table_rows.push_back('{MAXC, MAXC, MAXC, 1, zero_pt});
      table_rows.push_back('{MINC, MINC, MINC, 1, zero_pt});
      table_rows.push_back('{0, 0, 0, 1, zero_pt});
      foreach (table_rows[i])
         send_point(table_rows[i].x, table_rows[i].y, table_rows[i].z,
                    table_rows[i].typed, table_rows[i].want, 0);
      drain();

      // identity-like camera: depth from z, horizontal x, vertical y
      write_reg(CSR_DEPTH_ROW, {16'h4000, 16'h0000, 16'h0000});
      write_reg(CSR_HORIZONTAL_ROW, {16'h0000, 16'h0000, 16'h4000});
      write_reg(CSR_VERTICAL_ROW, {16'h0000, 16'h4000, 16'h0000});
      write_reg(CSR_SCREEN_CENTER, 48'({16'd540, 16'd960}));
      write_reg(CSR_PROJECTION_SCALE, 48'(32'd960 << 16));
      write_reg(CSR_CAMERA_Z, -48'sd2560);
      table_rows.delete();
      // depth exactly 1.0, in front, behind, and the extremes that saturate
      table_rows.push_back('{256, 256, -2304, 0, zero_pt});
      table_rows.push_back('{1000, -1000, 5000, 0, zero_pt});
      table_rows.push_back('{100, 100, -9000, 0, zero_pt});
      table_rows.push_back('{MAXC, MINC, 0, 0, zero_pt});
      table_rows.push_back('{MINC, MAXC, MAXC, 0, zero_pt});
      table_rows.push_back('{MAXC, MAXC, MINC, 0, zero_pt});
      table_rows.push_back('{-1, -1, -1, 0, zero_pt});
      foreach (table_rows[i])
         send_point(table_rows[i].x, table_rows[i].y, table_rows[i].z, 0, zero_pt, 0);
      drain();

      // zero scale puts every point on the center, extreme center too
      write_reg(CSR_PROJECTION_SCALE, 48'(0));
      write_reg(CSR_SCREEN_CENTER, 48'(32'hFFFF_FFFF));
      p.sx = 32'hFFFF << 8;
      p.sy = 32'hFFFF << 8;
      send_point(MAXC, MINC, 12345, 1, p, 0);
      send_point(MINC, MAXC, MINC, 1, p, 0);
      drain();
      // out-of-range register index is ignored
      write_reg(4'd8, 48'hFFFF_FFFF_FFFF);
      write_reg(4'd15, 48'h1234_5678_9ABC);
      send_point(0, 0, 0, 1, p, 0);
      drain();

      // maximum scale and extreme rows and camera
      write_reg(CSR_PROJECTION_SCALE, 48'(32'hFFFF_FFFF));
      write_reg(CSR_CAMERA_X, {16'h0, MINC});
      write_reg(CSR_CAMERA_Y, {16'hFFFF, MAXC});
      write_reg(CSR_HORIZONTAL_ROW, 48'h8000_8000_8000);
      write_reg(CSR_VERTICAL_ROW, 48'h7FFF_7FFF_7FFF);
      send_point(MAXC, MINC, 0, 0, zero_pt, 0);
      send_point(0, MAXC, MAXC, 0, zero_pt, 0);
      send_point(MINC, 0, MINC, 0, zero_pt, 0);
      drain();

      // random phases, each with its own configuration
      stall_enable = 1;
      for (int phase = 0; phase < 11; phase++) begin
         write_reg(CSR_CAMERA_X, 48'({$urandom, $urandom}));
         write_reg(CSR_CAMERA_Y, 48'({$urandom, $urandom}));
         write_reg(CSR_CAMERA_Z, 48'({$urandom, $urandom}));
         write_reg(CSR_DEPTH_ROW, rand_row(phase % 4 != 3));
         write_reg(CSR_HORIZONTAL_ROW, rand_row(phase % 4 != 3));
         write_reg(CSR_VERTICAL_ROW, rand_row(phase % 4 != 3));
         write_reg(CSR_PROJECTION_SCALE,
                   48'(phase % 3 == 0 ? $urandom : $urandom_range(0, 1 << 26)));
         write_reg(CSR_SCREEN_CENTER, 48'($urandom));
         if (phase % 3 == 1) begin
            write_reg(CSR_CAMERA_X, 48'($urandom_range(0, 4096) - 2048));
            write_reg(CSR_CAMERA_Y, 48'($urandom_range(0, 4096) - 2048));
            write_reg(CSR_CAMERA_Z, 48'($urandom_range(0, 4096) - 2048));
         end
         // long receiver hold-off while points keep coming
         if (phase == 2)
            fork
               begin
                  hold_long = 1;
                  repeat (LATENCY * 3) @(negedge clock);
                  hold_long = 0;
               end
            join_none
         for (int n = 0; n < N_RANDOM / 11; n++) begin
            if ($urandom_range(0, 2) == 0) begin
               x = $urandom; y = $urandom; z = $urandom;
            end else begin
               x = $urandom_range(0, 1 << 20) - (1 << 19);
               y = $urandom_range(0, 1 << 20) - (1 << 19);
               z = $urandom_range(0, 1 << 20) - (1 << 19);
            end
            send_point(x, y, z, 0, zero_pt, phase != 2 && (phase % 2 == 0 || n % 50 < 25));
         end
         drain();
      end

      stall_enable = 0;
      drain();
      if (errors == 0) begin
         $display("perspective_point_projection regression: pass");
      end else begin
         $display("perspective_point_projection regression: fail");
      end
      $finish;
   end

endmodule

/* perspective_point_projection.f */
hdl/ppp_pkg.sv
hdl/perspective_point_projection.sv
test/perspective_point_projection_test.sv
